// ===== src/sljx_pkg.sv =====
// shared types and constants for the sync/length/xor frame parser
// no dependencies; used by sljx_step and sync_length_xor_frame_parser
package sljx_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hBB;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_KIND  = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    localparam logic [2:0] ST_HUNT    = 3'd0;
    localparam logic [2:0] ST_HEADER  = 3'd1;
    localparam logic [2:0] ST_PAYLOAD = 3'd2;
    localparam logic [2:0] ST_GOOD    = 3'd3;
    localparam logic [2:0] ST_BAD     = 3'd4;
    localparam logic [2:0] ST_SYNC    = 3'd5;

    localparam int OUT_BITS = 35;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] running_xor;
        logic [7:0] byte_count;
        logic [7:0] held_kind;
        logic [7:0] held_length;
    } t_state;

    typedef struct packed {
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
        logic [7:0] payload_length;
        logic [7:0] frame_kind;
        logic [2:0] status;
    } t_result;

endpackage

// ===== src/sljx_step.sv =====
// per-byte next-state and result logic of the frame parser
// depends on sljx_pkg
module sljx_step (
    input  sljx_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    output sljx_pkg::t_state  o_state,
    output sljx_pkg::t_result o_result
);

    logic [7:0] w_count_inc;
    logic [2:0] w_status;
    logic [7:0] w_pbyte;
    logic [7:0] w_pindex;

    assign w_count_inc = i_state.byte_count + 8'd1;

    always_comb begin
        o_state  = i_state;
        w_status = sljx_pkg::ST_HUNT;
        w_pbyte  = 8'd0;
        w_pindex = 8'd0;
        if (i_state.phase != sljx_pkg::PH_CHECK) begin
            o_state.running_xor = i_state.running_xor ^ i_byte;
        end
        unique case (i_state.phase)
            sljx_pkg::PH_SYNC1: begin
                if (i_byte == sljx_pkg::SYNC_FIRST) begin
                    o_state.phase = sljx_pkg::PH_SYNC2;
                end
            end
            sljx_pkg::PH_SYNC2: begin
                if (i_byte == sljx_pkg::SYNC_SECOND) begin
                    o_state.phase       = sljx_pkg::PH_KIND;
                    o_state.running_xor = sljx_pkg::SYNC_FIRST ^ sljx_pkg::SYNC_SECOND;
                    w_status            = sljx_pkg::ST_SYNC;
                end else begin
                    o_state.phase = sljx_pkg::PH_SYNC1;
                end
            end
            sljx_pkg::PH_KIND: begin
                o_state.held_kind = i_byte;
                o_state.phase     = sljx_pkg::PH_LEN;
                w_status          = sljx_pkg::ST_HEADER;
            end
            sljx_pkg::PH_LEN: begin
                o_state.held_length = i_byte;
                o_state.byte_count  = 8'd0;
                o_state.phase       = (i_byte != 8'd0) ? sljx_pkg::PH_DATA
                                                       : sljx_pkg::PH_CHECK;
                w_status            = sljx_pkg::ST_HEADER;
            end
            sljx_pkg::PH_DATA: begin
                w_pbyte            = i_byte;
                w_pindex           = i_state.byte_count;
                o_state.byte_count = w_count_inc;
                if (w_count_inc >= i_state.held_length) begin
                    o_state.phase = sljx_pkg::PH_CHECK;
                end
                w_status = sljx_pkg::ST_PAYLOAD;
            end
            sljx_pkg::PH_CHECK: begin
                o_state.phase = sljx_pkg::PH_SYNC1;
                w_status = (i_state.running_xor == i_byte) ? sljx_pkg::ST_GOOD
                                                           : sljx_pkg::ST_BAD;
            end
            default: begin
                o_state.phase = sljx_pkg::PH_SYNC1;
            end
        endcase
    end

    always_comb begin
        o_result.status         = w_status;
        o_result.frame_kind     = o_state.held_kind;
        o_result.payload_length = o_state.held_length;
        o_result.payload_byte   = w_pbyte;
        o_result.payload_index  = w_pindex;
    end

endmodule

// ===== src/sync_length_xor_frame_parser.sv =====
// sync/length/xor frame parser: one result transaction per received byte
// an input transaction reaches its result transaction through the input register, then the result register
// throughput: one byte per cycle while the result is not stalled, set by the parser state update
// a stalled result holds while one more byte waits in the input register
// reset (synchronous, active low) clears both valid flags and the parser state
// depends on sljx_pkg and sljx_step
module sync_length_xor_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte[7:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // status[2:0], frame_kind[10:3], payload_length[18:11],
                                     // payload_byte[26:19], payload_index[34:27], zero fill
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    sljx_pkg::t_result r_out;
    sljx_pkg::t_state r_state;
    sljx_pkg::t_state n_state;
    sljx_pkg::t_result n_out;
    logic             w_out_free;
    logic             w_advance;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    sljx_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(sljx_pkg::OUT_TDATA_W - sljx_pkg::OUT_BITS){1'b0}}, r_out};

endmodule

// ===== src/sljx_checker.sv =====
// port-level assertions for sync_length_xor_frame_parser, bound to the top level
// depends on sljx_pkg
module sljx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);

    logic [2:0] w_status;
    assign w_status = o_m_tdata[2:0];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_status <= sljx_pkg::ST_SYNC)
        else $error("status code out of range");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_status != sljx_pkg::ST_PAYLOAD |-> o_m_tdata[34:19] == 16'd0)
        else $error("payload fields nonzero outside payload");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind sync_length_xor_frame_parser sljx_checker u_sljx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== verif/tb_sync_length_xor_frame_parser.sv =====
// self-checking testbench for sync_length_xor_frame_parser: directed table, then random frames
// and noise, with sender bursts and receiver stalls; every result is checked against typed-in values or a predictor
// depends on sljx_pkg and the parser rtl
module tb_sync_length_xor_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] rx;
        bit         typed;
        logic [2:0] status;
        logic [7:0] kind;
        logic [7:0] len;
    } t_dir_row;

    typedef struct packed {
        bit                typed;
        sljx_pkg::t_result res;
    } t_rx_pending;

    localparam int DIR_ROWS_N = 24;
    localparam int RANDOM_BYTES = 2000;

    // expected values typed in for hunting, header, sync and checksum rows
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        '{8'h00,                 1'b1, sljx_pkg::ST_HUNT,    8'h00, 8'h00},
        '{8'hFF,                 1'b1, sljx_pkg::ST_HUNT,    8'h00, 8'h00},
        '{sljx_pkg::SYNC_FIRST,  1'b1, sljx_pkg::ST_HUNT,    8'h00, 8'h00},
        // bad second sync byte, not retried as first sync byte
        '{sljx_pkg::SYNC_FIRST,  1'b1, sljx_pkg::ST_HUNT,    8'h00, 8'h00},
        '{sljx_pkg::SYNC_SECOND, 1'b1, sljx_pkg::ST_HUNT,    8'h00, 8'h00},
        '{sljx_pkg::SYNC_FIRST,  1'b1, sljx_pkg::ST_HUNT,    8'h00, 8'h00},
        '{sljx_pkg::SYNC_SECOND, 1'b1, sljx_pkg::ST_SYNC,    8'h00, 8'h00},
        '{8'h80,                 1'b1, sljx_pkg::ST_HEADER,  8'h80, 8'h00},
        // zero length goes straight to the check byte
        '{8'h00,                 1'b1, sljx_pkg::ST_HEADER,  8'h80, 8'h00},
        '{8'h91,                 1'b1, sljx_pkg::ST_GOOD,    8'h80, 8'h00},
        // held values stay visible while hunting
        '{sljx_pkg::SYNC_FIRST,  1'b1, sljx_pkg::ST_HUNT,    8'h80, 8'h00},
        '{sljx_pkg::SYNC_SECOND, 1'b1, sljx_pkg::ST_SYNC,    8'h80, 8'h00},
        '{8'h7F,                 1'b1, sljx_pkg::ST_HEADER,  8'h7F, 8'h00},
        '{8'h03,                 1'b1, sljx_pkg::ST_HEADER,  8'h7F, 8'h03},
        '{8'h00,                 1'b0, sljx_pkg::ST_PAYLOAD, 8'h00, 8'h00},
        '{8'hFF,                 1'b0, sljx_pkg::ST_PAYLOAD, 8'h00, 8'h00},
        '{8'hA5,                 1'b0, sljx_pkg::ST_PAYLOAD, 8'h00, 8'h00},
        '{8'h00,                 1'b1, sljx_pkg::ST_BAD,     8'h7F, 8'h03},
        '{sljx_pkg::SYNC_FIRST,  1'b1, sljx_pkg::ST_HUNT,    8'h7F, 8'h03},
        '{sljx_pkg::SYNC_SECOND, 1'b1, sljx_pkg::ST_SYNC,    8'h7F, 8'h03},
        '{8'hFF,                 1'b1, sljx_pkg::ST_HEADER,  8'hFF, 8'h03},
        '{8'h01,                 1'b1, sljx_pkg::ST_HEADER,  8'hFF, 8'h01},
        '{8'h5A,                 1'b0, sljx_pkg::ST_PAYLOAD, 8'h00, 8'h00},
        '{8'hB5,                 1'b1, sljx_pkg::ST_GOOD,    8'hFF, 8'h01}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;

    // predictor state
    logic [2:0] rx_phase = sljx_pkg::PH_SYNC1;
    logic [7:0] rx_xor = 8'h00;
    logic [7:0] rx_count = 8'h00;
    logic [7:0] rx_kind = 8'h00;
    logic [7:0] rx_length = 8'h00;

    t_rx_pending       rx_pending_q[$];
    sljx_pkg::t_result frame_expect_q[$];
    int                mismatch_count = 0;
    int                rx_sent = 0;
    int                burst_left = 0;
    int                ready_mode = 0;
    int                ready_tick = 0;

    sync_length_xor_frame_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic sljx_pkg::t_result parse_byte(input logic [7:0] b);
        sljx_pkg::t_result r;
        r = '0;
        r.status = sljx_pkg::ST_HUNT;
        if (rx_phase != sljx_pkg::PH_CHECK) begin
            rx_xor = rx_xor ^ b;
        end
        case (rx_phase)
            sljx_pkg::PH_SYNC1: begin
                if (b == sljx_pkg::SYNC_FIRST) rx_phase = sljx_pkg::PH_SYNC2;
            end
            sljx_pkg::PH_SYNC2: begin
                if (b == sljx_pkg::SYNC_SECOND) begin
                    rx_phase = sljx_pkg::PH_KIND;
                    rx_xor = sljx_pkg::SYNC_FIRST ^ sljx_pkg::SYNC_SECOND;
                    r.status = sljx_pkg::ST_SYNC;
                end else begin
                    rx_phase = sljx_pkg::PH_SYNC1;
                end
            end
            sljx_pkg::PH_KIND: begin
                rx_kind = b;
                rx_phase = sljx_pkg::PH_LEN;
                r.status = sljx_pkg::ST_HEADER;
            end
            sljx_pkg::PH_LEN: begin
                rx_length = b;
                rx_count = 8'h00;
                rx_phase = (b != 8'h00) ? sljx_pkg::PH_DATA : sljx_pkg::PH_CHECK;
                r.status = sljx_pkg::ST_HEADER;
            end
            sljx_pkg::PH_DATA: begin
                r.payload_byte = b;
                r.payload_index = rx_count;
                rx_count = rx_count + 8'd1;
                if (rx_count >= rx_length) rx_phase = sljx_pkg::PH_CHECK;
                r.status = sljx_pkg::ST_PAYLOAD;
            end
            sljx_pkg::PH_CHECK: begin
                rx_phase = sljx_pkg::PH_SYNC1;
                r.status = (rx_xor == b) ? sljx_pkg::ST_GOOD : sljx_pkg::ST_BAD;
            end
            default: begin
                rx_phase = sljx_pkg::PH_SYNC1;
            end
        endcase
        r.frame_kind = rx_kind;
        r.payload_length = rx_length;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t ns: %s expected %02h got %02h", $realtime, field, want, got);
        mismatch_count++;
    endtask

    // transaction monitor: predict on input, compare on output
    always @(posedge i_clk) begin : monitor
        sljx_pkg::t_result pred;
        sljx_pkg::t_result want;
        sljx_pkg::t_result got;
        t_rx_pending       row;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                pred = parse_byte(i_s_tdata);
                row = rx_pending_q.pop_front();
                frame_expect_q.push_back(row.typed ? row.res : pred);
            end
            if (o_m_tvalid && i_m_tready) begin
                got = sljx_pkg::t_result'(o_m_tdata[sljx_pkg::OUT_BITS-1:0]);
                if (frame_expect_q.size() == 0) begin
                    report_mismatch("unexpected result, status", 8'h00, 8'(got.status));
                end else begin
                    want = frame_expect_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 8'(want.status), 8'(got.status));
                    if (got.frame_kind != want.frame_kind)
                        report_mismatch("frame_kind", want.frame_kind, got.frame_kind);
                    if (got.payload_length != want.payload_length)
                        report_mismatch("payload_length", want.payload_length,
                                        got.payload_length);
                    if (got.payload_byte != want.payload_byte)
                        report_mismatch("payload_byte", want.payload_byte, got.payload_byte);
                    if (got.payload_index != want.payload_index)
                        report_mismatch("payload_index", want.payload_index,
                                        got.payload_index);
                    if (o_m_tdata[sljx_pkg::OUT_TDATA_W-1:sljx_pkg::OUT_BITS] != '0)
                        report_mismatch("tdata fill", 8'h00,
                            8'(o_m_tdata[sljx_pkg::OUT_TDATA_W-1:sljx_pkg::OUT_BITS]));
                end
            end
        end
    end

    // receiver stalls: a randomly chosen mode sets the ready pattern
    always @(negedge i_clk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 97 == 0) ready_mode <= int'($urandom_range(0, 3));
        case (ready_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(0, 3) != 0);
            2:       i_m_tready <= (ready_tick % 4 == 0);
            default: i_m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    task automatic send_rx_byte(input logic [7:0] b, input bit typed,
                                input sljx_pkg::t_result res);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : int'($urandom_range(1, 40));
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        rx_pending_q.push_back('{typed, res});
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        rx_sent++;
    endtask

    task automatic send_frame(input bit corrupt);
        logic [7:0] kind;
        logic [7:0] len;
        logic [7:0] csum;
        logic [7:0] b;
        int         pick;
        kind = 8'($urandom_range(0, 255));
        pick = int'($urandom_range(0, 99));
        if (pick < 3) len = 8'hFF;
        else if (pick < 12) len = 8'h00;
        else len = 8'($urandom_range(1, 12));
        csum = sljx_pkg::SYNC_FIRST ^ sljx_pkg::SYNC_SECOND ^ kind ^ len;
        send_rx_byte(sljx_pkg::SYNC_FIRST, 1'b0, '0);
        send_rx_byte(sljx_pkg::SYNC_SECOND, 1'b0, '0);
        send_rx_byte(kind, 1'b0, '0);
        send_rx_byte(len, 1'b0, '0);
        for (int i = 0; i < int'(len); i++) begin
            b = 8'($urandom_range(0, 255));
            csum = csum ^ b;
            send_rx_byte(b, 1'b0, '0);
        end
        if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
        send_rx_byte(csum, 1'b0, '0);
    endtask

    // line noise and broken sync pairs
    task automatic send_noise();
        int         n;
        int         pick;
        logic [7:0] b;
        n = int'($urandom_range(1, 6));
        for (int i = 0; i < n; i++) begin
            pick = int'($urandom_range(0, 5));
            if (pick < 2) b = sljx_pkg::SYNC_FIRST;
            else if (pick == 2) b = sljx_pkg::SYNC_SECOND;
            else b = 8'($urandom_range(0, 255));
            send_rx_byte(b, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        sljx_pkg::t_result typed_res;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS_N; i++) begin
            typed_res = '0;
            typed_res.status = DIR_ROWS[i].status;
            typed_res.frame_kind = DIR_ROWS[i].kind;
            typed_res.payload_length = DIR_ROWS[i].len;
            send_rx_byte(DIR_ROWS[i].rx, DIR_ROWS[i].typed, typed_res);
        end

        rx_sent = 0;
        while (rx_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) < 7) send_frame($urandom_range(0, 3) == 0);
            else send_noise();
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        while (rx_pending_q.size() != 0 || frame_expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
